/* rtl/core/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, codes and character constants of the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // work for the back end
    typedef enum logic [1:0] {
        OP_LIT = 2'd0,  // one byte as is
        OP_ESC = 2'd1,  // backslash then one byte
        OP_UNI = 2'd2,  // backslash u 0 0 hex hex
        OP_ERR = 2'd3   // single error beat
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] ch;
    } t_desc;

    // position within an expanded escape
    typedef logic [2:0] t_idx;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6e;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;

    // one lowercase hex digit
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    // number of beats an operation expands to, minus one
    function automatic t_idx last_idx(input t_op op);
        t_idx r;
        unique case (op)
            OP_LIT:  r = 3'd0;
            OP_ESC:  r = 3'd1;
            OP_UNI:  r = 3'd5;
            OP_ERR:  r = 3'd0;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/jse_if.sv */
// ----------------------------------------------------------------------------
// jse_in_if / jse_out_if
// valid/ready channels of the json string escaper
// ----------------------------------------------------------------------------
interface jse_in_if;
    logic                       valid;
    logic                       ready;
    logic [jse_pkg::KIND_W-1:0] kind;
    logic [jse_pkg::BYTE_W-1:0] char_byte;

    modport source (output valid, output kind, output char_byte, input ready);
    modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface jse_out_if;
    logic                       valid;
    logic                       ready;
    logic [jse_pkg::BYTE_W-1:0] out_byte;
    logic                       last;
    logic                       status;

    modport source (output valid, output out_byte, output last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    output ready);
endinterface

/* rtl/core/jse_front.sv */
// ----------------------------------------------------------------------------
// jse_front
// accepts input beats, tracks the failed-string flag, classifies characters
// ----------------------------------------------------------------------------
module jse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jse_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output jse_pkg::t_desc o_desc
);
    import jse_pkg::*;

    logic  r_failed;
    logic  n_failed;
    logic  w_emit;
    t_desc w_desc;
    logic  w_acc;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        n_failed  = r_failed;
        w_emit    = 1'b0;
        w_desc.op = OP_LIT;
        w_desc.ch = CH_QUOTE;
        unique case (t_kind'(i_in.kind))
            KIND_BEGIN: begin
                n_failed = 1'b0;
                w_emit   = 1'b1;
            end
            KIND_END: begin
                w_emit = !r_failed;
            end
            KIND_CHAR: begin
                w_emit    = !r_failed;
                w_desc.ch = i_in.char_byte;
                if (i_in.char_byte[BYTE_W-1]) begin
                    w_desc.op = OP_ERR;
                    n_failed  = 1'b1;
                end else begin
                    unique case (i_in.char_byte)
                        CH_QUOTE:  w_desc.op = OP_ESC;
                        CH_BSLASH: w_desc.op = OP_ESC;
                        CH_BS: begin
                            w_desc.op = OP_ESC;
                            w_desc.ch = CH_LOW_B;
                        end
                        CH_FF: begin
                            w_desc.op = OP_ESC;
                            w_desc.ch = CH_LOW_F;
                        end
                        CH_LF: begin
                            w_desc.op = OP_ESC;
                            w_desc.ch = CH_LOW_N;
                        end
                        CH_CR: begin
                            w_desc.op = OP_ESC;
                            w_desc.ch = CH_LOW_R;
                        end
                        CH_TAB: begin
                            w_desc.op = OP_ESC;
                            w_desc.ch = CH_LOW_T;
                        end
                        default: begin
                            if (i_in.char_byte < CTRL_LIMIT) begin
                                w_desc.op = OP_UNI;
                            end
                        end
                    endcase
                end
                if (r_failed) begin
                    n_failed = r_failed;
                end
            end
            default: begin
                // unused kind: dropped
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b0;
        end else if (w_acc) begin
            r_failed <= n_failed;
        end
    end

    assign o_push = w_acc && w_emit;
    assign o_desc = w_desc;

endmodule

/* rtl/core/jse_queue.sv */
// ----------------------------------------------------------------------------
// jse_queue
// small register queue of descriptors between front and back
// ----------------------------------------------------------------------------
module jse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jse_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output jse_pkg::t_desc o_desc
);
    import jse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/jse_back.sv */
// ----------------------------------------------------------------------------
// jse_back
// expands one descriptor into its output beats through an output register
// ----------------------------------------------------------------------------
module jse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jse_pkg::t_desc i_desc,
    output logic           o_pop,
    jse_out_if.source      o_out
);
    import jse_pkg::*;

    t_idx              r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_status;

    logic              w_load;
    logic              w_fin;
    logic [BYTE_W-1:0] w_byte;

    assign w_load = i_q_valid && (!r_valid || o_out.ready);
    assign w_fin  = (r_idx == last_idx(i_desc.op));
    assign o_pop  = w_load && w_fin;

    always_comb begin
        w_byte = i_desc.ch;
        unique case (i_desc.op)
            OP_LIT: w_byte = i_desc.ch;
            OP_ESC: w_byte = (r_idx == 3'd0) ? CH_BSLASH : i_desc.ch;
            OP_UNI: begin
                case (r_idx)
                    3'd0:    w_byte = CH_BSLASH;
                    3'd1:    w_byte = CH_LOW_U;
                    3'd2:    w_byte = CH_ZERO;
                    3'd3:    w_byte = CH_ZERO;
                    3'd4:    w_byte = hex_digit(i_desc.ch[7:4]);
                    default: w_byte = hex_digit(i_desc.ch[3:0]);
                endcase
            end
            OP_ERR:  w_byte = '0;
            default: w_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_fin ? '0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= w_byte;
            r_last   <= w_fin;
            r_status <= (i_desc.op == OP_ERR);
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;
    assign o_out.status   = r_status;

endmodule

/* rtl/core/json_string_escaper_top.sv */
// ----------------------------------------------------------------------------
// json_string_escaper_top
// streams a string out as a quoted, ascii-only json string literal
// ----------------------------------------------------------------------------
// one input beat is taken per cycle whenever the two-entry descriptor queue
// has room. a begin beat gives an opening quote, an end beat a closing quote,
// a character beat its escaped form: one output beat for a plain character,
// two for a quote, backslash or one of \b \f \n \r \t, and six (\u00hh) for
// any other byte below 0x20. a byte of 0x80 or above gives one beat with
// out_byte 0 and status 1, after which the rest of that string gives nothing
// until the next begin beat; kind 3 is dropped. the output side moves one
// beat per cycle while ready is high, so plain text runs at one item per
// cycle, passing through the descriptor queue and the output register, while
// an escape holds the back end for all of its beats and input stalls once the
// queue fills. the last flag marks the final beat of each input item.
// ----------------------------------------------------------------------------
module json_string_escaper_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);
    import jse_pkg::*;

    // front to queue
    logic  w_push;
    t_desc w_push_desc;
    logic  w_q_full;

    // queue to back
    logic  w_q_valid;
    t_desc w_q_desc;
    logic  w_pop;

    // front: handshake, failed-string flag, classification
    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_desc   (w_push_desc)
    );

    // decouples classification from expansion
    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    // back: beat sequencer and output register
    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_desc    (w_q_desc),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
